>>> rtl/rpr_pkg.sv
`default_nettype none
package rpr_pkg;

  localparam int ARRAY_DEPTH   = 64;
  localparam int PATTERN_DEPTH = 16;
  localparam int WORD_W        = 32;

  // address and count widths
  localparam int AW  = $clog2(ARRAY_DEPTH);
  localparam int CW  = $clog2(ARRAY_DEPTH + 1);
  localparam int PW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int IW  = (CW > PCW) ? CW : PCW;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_PUSH_ARRAY   = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_START        = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage
`default_nettype wire

>>> rtl/repeated_pattern_removal_top.sv
`default_nettype none
// Repeated pattern removal. Items on in_* push an array word (opcode 0) or a
// pattern word (opcode 1); opcode 2 starts a run that deletes the leftmost
// occurrence of the pattern again and again until none is left, then streams
// the remaining words on out_* with tlast on the final one, or one empty
// marker if nothing remained, and clears both stores. The block takes one
// push every cycle while idle. A start holds in_tready low while it runs:
// unless the pattern is empty, the array is swept once with a compaction
// stack held in the array memory itself, then the remaining words are
// emitted, more slowly while out_tready is low. The pace is set by the
// single read port of the array memory.
module repeated_pattern_removal_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic signed [rpr_pkg::WORD_W-1:0] in_tdata,  // word
  input  wire logic [rpr_pkg::OP_W-1:0]       in_tuser,     // opcode
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic signed [rpr_pkg::WORD_W-1:0]   out_tdata,    // word_res
  output logic                                out_tlast,    // is_last
  output logic [1:0]                          out_tuser     // is_empty, overflowed
);
  import rpr_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_COPY_RD   = 3'd1;
  localparam logic [2:0] S_COPY_WAIT = 3'd2;
  localparam logic [2:0] S_CMP_RD    = 3'd3;
  localparam logic [2:0] S_CMP_CHK   = 3'd4;
  localparam logic [2:0] S_EMIT_RD   = 3'd5;
  localparam logic [2:0] S_EMIT_LD   = 3'd6;

  word_t             arr_mem [ARRAY_DEPTH];
  word_t             pat_mem [PATTERN_DEPTH];
  word_t             arr_rd_r;
  word_t             pat_rd_r;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     arr_cnt_r, arr_cnt_nxt;
  logic [PCW-1:0]    pat_cnt_r, pat_cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;   // read side, also emit index
  logic [CW-1:0]     wr_idx_r, wr_idx_nxt;   // top of compaction stack
  logic [PW-1:0]     j_r, j_nxt;

  logic              out_valid_r, out_valid_nxt;
  word_t             out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              in_acc;
  logic              out_free;
  logic [IW-1:0]     wr_ext, pat_ext, j_ext, wr_inc_ext, tail_ext;
  logic [AW-1:0]     arr_raddr;
  logic              arr_we;
  logic [AW-1:0]     arr_waddr;
  word_t             arr_wdata;
  logic              pat_we;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  assign wr_ext     = IW'(wr_idx_r);
  assign pat_ext    = IW'(pat_cnt_r);
  assign j_ext      = IW'(j_r);
  assign wr_inc_ext = wr_ext + IW'(1);
  assign tail_ext   = wr_ext - pat_ext + j_ext;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

  // array read address
  always_comb begin
    unique case (state_r)
      S_CMP_RD: arr_raddr = tail_ext[AW-1:0];
      default:  arr_raddr = rd_idx_r[AW-1:0];
    endcase
  end

  // array write port: pushes in idle, stack writes while compacting
  always_comb begin
    arr_we    = 1'b0;
    arr_waddr = arr_cnt_r[AW-1:0];
    arr_wdata = in_tdata;
    pat_we    = 1'b0;
    if (in_acc && in_tuser == OP_PUSH_ARRAY && arr_cnt_r < CW'(ARRAY_DEPTH)) begin
      arr_we = 1'b1;
    end
    if (in_acc && in_tuser == OP_PUSH_PATTERN && pat_cnt_r < PCW'(PATTERN_DEPTH)) begin
      pat_we = 1'b1;
    end
    if (state_r == S_COPY_WAIT) begin
      arr_we    = 1'b1;
      arr_waddr = wr_idx_r[AW-1:0];
      arr_wdata = arr_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr_mem[arr_waddr] <= arr_wdata;
    end
    if (pat_we) begin
      pat_mem[pat_cnt_r[PW-1:0]] <= in_tdata;
    end
    arr_rd_r <= arr_mem[arr_raddr];
    pat_rd_r <= pat_mem[j_r];
  end

  always_comb begin
    state_nxt     = state_r;
    arr_cnt_nxt   = arr_cnt_r;
    pat_cnt_nxt   = pat_cnt_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_tuser == OP_PUSH_ARRAY) begin
            if (arr_we) begin
              arr_cnt_nxt = arr_cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (in_tuser == OP_PUSH_PATTERN) begin
            if (pat_we) begin
              pat_cnt_nxt = pat_cnt_r + PCW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (in_tuser == OP_START) begin
            rd_idx_nxt = '0;
            wr_idx_nxt = '0;
            // empty pattern removes nothing
            state_nxt  = (pat_cnt_r == '0) ? S_EMIT_RD : S_COPY_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_COPY_RD: begin
        if (rd_idx_r == arr_cnt_r) begin
          arr_cnt_nxt = wr_idx_r;
          rd_idx_nxt  = '0;
          state_nxt   = S_EMIT_RD;
        end else begin
          state_nxt = S_COPY_WAIT;
        end
      end
      S_COPY_WAIT: begin
        wr_idx_nxt = wr_idx_r + CW'(1);
        rd_idx_nxt = rd_idx_r + CW'(1);
        j_nxt      = '0;
        state_nxt  = (wr_inc_ext >= pat_ext) ? S_CMP_RD : S_COPY_RD;
      end
      S_CMP_RD: begin
        state_nxt = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (arr_rd_r != pat_rd_r) begin
          state_nxt = S_COPY_RD;
        end else if (j_ext + IW'(1) == pat_ext) begin
          // tail of the stack matches: pop the pattern
          wr_idx_nxt = CW'(wr_ext - pat_ext);
          state_nxt  = S_COPY_RD;
        end else begin
          j_nxt     = j_r + PW'(1);
          state_nxt = S_CMP_RD;
        end
      end
      S_EMIT_RD: begin
        if (out_free) begin
          if (arr_cnt_r == '0) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b1;
            out_ovf_nxt   = ovf_r;
            pat_cnt_nxt   = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_EMIT_LD;
          end
        end
      end
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = arr_rd_r;
        out_last_nxt  = (rd_idx_r + CW'(1) == arr_cnt_r);
        out_empty_nxt = 1'b0;
        out_ovf_nxt   = ovf_r;
        rd_idx_nxt    = rd_idx_r + CW'(1);
        if (rd_idx_r + CW'(1) == arr_cnt_r) begin
          arr_cnt_nxt = '0;
          pat_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arr_cnt_r   <= '0;
      pat_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arr_cnt_r   <= arr_cnt_nxt;
      pat_cnt_r   <= pat_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    wr_idx_r    <= wr_idx_nxt;
    j_r         <= j_nxt;
    out_word_r  <= out_word_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  a_arr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    arr_cnt_r <= CW'(ARRAY_DEPTH))
    else $error("array count beyond depth");

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT_LD |-> !out_valid_r)
    else $error("result register overwritten");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == '0)
    else $error("empty marker malformed");

  a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP_RD |-> wr_ext >= pat_ext && j_ext < pat_ext)
    else $error("compare outside stack");

  a_stack_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COPY_WAIT |-> wr_idx_r <= rd_idx_r && rd_idx_r < arr_cnt_r)
    else $error("stack pointer ahead of read pointer");

endmodule
`default_nettype wire
